>>> src/msis_pkg.sv
`default_nettype none

package msis_pkg;

  localparam int NoteCount    = 128;
  localparam int PatternCount = 19;
  localparam int Latency      = 7;

  localparam logic [4:0] ResetPattern = 5'd1;
  localparam logic [6:0] ResetRoot    = 7'd60;
  localparam logic [3:0] ResetBase    = 4'(ResetRoot % 12);

  typedef enum logic [0:0] {
    RegPattern = 1'b0,
    RegRoot    = 1'b1
  } cfg_reg_e;

  // per pattern: offset of the j-th scale note within the octave
  typedef logic [11:0][3:0] offset_row_t;
  typedef offset_row_t [PatternCount-1:0] offset_tbl_t;

  localparam logic [11:0] OffsetMasks [PatternCount] = '{
    12'hFFF, 12'hAB5, 12'h6AD, 12'h5AB, 12'hAD5, 12'h6B5, 12'h5AD, 12'h56B, 12'h9AD, 12'hAAD,
    12'h295, 12'h4A9, 12'h4E9, 12'hEB5, 12'hB6D, 12'hD53, 12'hAAB, 12'h9AB, 12'h9CD
  };

  function automatic offset_tbl_t build_offset_tbl();
    offset_tbl_t tbl;
    int c;
    tbl = '0;
    for (int p = 0; p < PatternCount; p++) begin
      c = 0;
      for (int i = 0; i < 12; i++) begin
        if (OffsetMasks[p][i]) begin
          tbl[p][c] = 4'(i);
          c++;
        end
      end
    end
    return tbl;
  endfunction

  localparam offset_tbl_t OffsetTbl = build_offset_tbl();

  function automatic logic [11:0] pattern_mask(logic [4:0] p);
    if (p < 5'(PatternCount)) begin
      return OffsetMasks[p];
    end
    return 12'h001;
  endfunction

  function automatic offset_row_t pattern_offsets(logic [4:0] p);
    if (p < 5'(PatternCount)) begin
      return OffsetTbl[p];
    end
    return '0;
  endfunction

  function automatic logic [3:0] ones12(logic [11:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 12; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

  // bits below position r set
  function automatic logic [11:0] low_bits(logic [3:0] r);
    logic [11:0] m;
    for (int i = 0; i < 12; i++) begin
      m[i] = (4'(i) < r);
    end
    return m;
  endfunction

  // {quotient, remainder} of v / 12 by reciprocal multiply and one correction
  function automatic logic [7:0] div12(logic [7:0] v);
    logic [13:0] prod;
    logic [3:0]  q;
    logic [7:0]  r;
    prod = 14'(v) * 14'd43;
    q    = prod[12:9];
    r    = v - 8'(q) * 8'd12;
    if (r >= 8'd12) begin
      q = q + 4'd1;
      r = r - 8'd12;
    end
    return {q, r[3:0]};
  endfunction

  // one restoring division step, returns {quotient bit, remainder}
  function automatic logic [4:0] div_step(logic [3:0] rem, logic bit_in, logic [3:0] k);
    logic [4:0] tmp;
    logic [4:0] diff;
    tmp  = {rem, bit_in};
    diff = tmp - {1'b0, k};
    if (tmp >= {1'b0, k}) begin
      return {1'b1, diff[3:0]};
    end
    return {1'b0, tmp[3:0]};
  endfunction

endpackage

`default_nettype wire

>>> src/musical_scale_interval_stepper.sv
`default_nettype none

// Scale stepper: takes one request per clock (start_i) and never stalls the sender, so busy_o
// stays low. Each request gives exactly one result, shown for a single cycle with done_o;
// the receiver has no way to stall it. The path has seven register stages: octave split of the
// note, count of scale notes below it, add of the interval, a three-stage divide of the target
// position by the notes per octave, and the output register.
// Writes to the pattern and root registers take effect on the next cycle and must only happen
// while no request is in flight.
module musical_scale_interval_stepper #(
  parameter int NoteCount = msis_pkg::NoteCount
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [6:0]        from_note_i,
  input  logic signed [7:0] interval_steps_i,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [6:0]        cfg_wdata_i,
  output logic              done_o,
  output logic [6:0]        to_note_o,
  output logic              in_range_o,
  output logic [6:0]        target_index_o,
  output logic [3:0]        scale_degree_o
);

  localparam logic [7:0] NoteLimit = 8'(NoteCount);

  typedef struct packed {
    logic       zero;
    logic       inr;
    logic [6:0] from;
    logic [6:0] below;
    logic [6:0] tgt;
  } carry_t;

  // scale setup, derived at write time
  logic [11:0]                mask_q;
  logic [3:0]                 k_q;
  msis_pkg::offset_row_t      row_q;
  logic [3:0]                 base_q;
  logic [7:0]                 root_div;

  assign root_div = msis_pkg::div12({1'b0, cfg_wdata_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= msis_pkg::pattern_mask(msis_pkg::ResetPattern);
      k_q    <= msis_pkg::ones12(msis_pkg::pattern_mask(msis_pkg::ResetPattern));
      row_q  <= msis_pkg::pattern_offsets(msis_pkg::ResetPattern);
      base_q <= msis_pkg::ResetBase;
    end else if (cfg_we_i) begin
      case (msis_pkg::cfg_reg_e'(cfg_idx_i))
        msis_pkg::RegPattern: begin
          mask_q <= msis_pkg::pattern_mask(cfg_wdata_i[4:0]);
          k_q    <= msis_pkg::ones12(msis_pkg::pattern_mask(cfg_wdata_i[4:0]));
          row_q  <= msis_pkg::pattern_offsets(cfg_wdata_i[4:0]);
        end
        msis_pkg::RegRoot: begin
          base_q <= root_div[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign busy_o = 1'b0;

  // valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      done_q <= v6_q;
    end
  end

  // stage 1: octave split of note and of scale end
  logic [7:0] lim_d, db_d, da_d, divb_d, diva_d;
  logic [3:0] octb1_q, remb1_q, octa1_q, rema1_q;
  logic [6:0] from1_q;
  logic [7:0] iv1_q;

  always_comb begin
    lim_d  = ({1'b0, from_note_i} >= NoteLimit) ? NoteLimit : {1'b0, from_note_i};
    db_d   = (lim_d > {4'b0, base_q}) ? (lim_d - {4'b0, base_q}) : 8'd0;
    da_d   = NoteLimit - {4'b0, base_q};
    divb_d = msis_pkg::div12(db_d);
    diva_d = msis_pkg::div12(da_d);
  end

  always_ff @(posedge clk_i) begin
    octb1_q <= divb_d[7:4];
    remb1_q <= divb_d[3:0];
    octa1_q <= diva_d[7:4];
    rema1_q <= diva_d[3:0];
    from1_q <= from_note_i;
    iv1_q   <= interval_steps_i;
  end

  // stage 2: scale notes below the input note and in the whole range
  logic [7:0] below_d, count_d;
  logic [7:0] below2_q, count2_q;
  logic [6:0] from2_q;
  logic [7:0] iv2_q;

  always_comb begin
    below_d = ({4'b0, octb1_q} * {4'b0, k_q})
            + {4'b0, msis_pkg::ones12(mask_q & msis_pkg::low_bits(remb1_q))};
    count_d = ({4'b0, octa1_q} * {4'b0, k_q})
            + {4'b0, msis_pkg::ones12(mask_q & msis_pkg::low_bits(rema1_q))};
  end

  always_ff @(posedge clk_i) begin
    below2_q <= below_d;
    count2_q <= count_d;
    from2_q  <= from1_q;
    iv2_q    <= iv1_q;
  end

  // stage 3: target position and range check
  logic signed [9:0] tgt_d;
  carry_t            c3_d, c3_q;

  always_comb begin
    tgt_d     = $signed({2'b00, below2_q}) + $signed({{2{iv2_q[7]}}, iv2_q});
    c3_d.zero = (iv2_q == 8'd0);
    c3_d.inr  = !tgt_d[9] && (tgt_d[8:0] < {1'b0, count2_q});
    c3_d.from = from2_q;
    c3_d.below = below2_q[6:0];
    c3_d.tgt  = tgt_d[6:0];
  end

  always_ff @(posedge clk_i) begin
    c3_q <= c3_d;
  end

  // stages 4..6: target / notes per octave, quotient bits 6..4, 3..2, 1..0
  carry_t     c4_q, c5_q, c6_q;
  logic [2:0] q4_d, q4_q;
  logic [4:0] q5_d, q5_q;
  logic [6:0] q6_d, q6_q;
  logic [3:0] r4_d, r4_q, r5_d, r5_q, r6_d, r6_q;
  logic [4:0] st4, st5, st6;

  always_comb begin
    r4_d = '0;
    q4_d = '0;
    st4  = '0;
    for (int i = 0; i < 3; i++) begin
      st4         = msis_pkg::div_step(r4_d, c3_q.tgt[6-i], k_q);
      r4_d        = st4[3:0];
      q4_d[2-i]   = st4[4];
    end
  end

  always_comb begin
    r5_d = r4_q;
    q5_d = {q4_q, 2'b00};
    st5  = '0;
    for (int i = 0; i < 2; i++) begin
      st5         = msis_pkg::div_step(r5_d, c4_q.tgt[3-i], k_q);
      r5_d        = st5[3:0];
      q5_d[1-i]   = st5[4];
    end
  end

  always_comb begin
    r6_d = r5_q;
    q6_d = {q5_q, 2'b00};
    st6  = '0;
    for (int i = 0; i < 2; i++) begin
      st6         = msis_pkg::div_step(r6_d, c5_q.tgt[1-i], k_q);
      r6_d        = st6[3:0];
      q6_d[1-i]   = st6[4];
    end
  end

  always_ff @(posedge clk_i) begin
    c4_q <= c3_q;
    q4_q <= q4_d;
    r4_q <= r4_d;
    c5_q <= c4_q;
    q5_q <= q5_d;
    r5_q <= r5_d;
    c6_q <= c5_q;
    q6_q <= q6_d;
    r6_q <= r6_d;
  end

  // stage 7: note from octave and offset, output register
  logic [10:0] oct12_d, note_d;
  logic [3:0]  off_d;
  logic [6:0]  to_note_d, index_d;
  logic        in_range_d;
  logic [3:0]  degree_d;
  logic [6:0]  to_note_q, index_q;
  logic        in_range_q;
  logic [3:0]  degree_q;

  always_comb begin
    oct12_d = ({4'b0, q6_q} << 3) + ({4'b0, q6_q} << 2);
    off_d   = (r6_q <= 4'd11) ? row_q[r6_q] : 4'd0;
    note_d  = {7'b0, base_q} + oct12_d + {7'b0, off_d};
    if (c6_q.zero) begin
      to_note_d  = c6_q.from;
      in_range_d = 1'b1;
      index_d    = c6_q.below;
      degree_d   = 4'd0;
    end else if (c6_q.inr) begin
      to_note_d  = note_d[6:0];
      in_range_d = 1'b1;
      index_d    = c6_q.tgt;
      degree_d   = r6_q + 4'd1;
    end else begin
      to_note_d  = '0;
      in_range_d = 1'b0;
      index_d    = '0;
      degree_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    to_note_q  <= to_note_d;
    in_range_q <= in_range_d;
    index_q    <= index_d;
    degree_q   <= degree_d;
  end

  assign done_o         = done_q;
  assign to_note_o      = to_note_q;
  assign in_range_o     = in_range_q;
  assign target_index_o = index_q;
  assign scale_degree_o = degree_q;

endmodule

`default_nettype wire

>>> src/msis_checker.sv
`default_nettype none

module msis_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_o,
  input  logic [6:0]        from_note_i,
  input  logic signed [7:0] interval_steps_i,
  input  logic              done_o,
  input  logic [6:0]        to_note_o,
  input  logic              in_range_o,
  input  logic [6:0]        target_index_o,
  input  logic [3:0]        scale_degree_o
);

  localparam int AgeW = $clog2(msis_pkg::Latency + 1);

  // cycles since reset release, saturating at the latency
  logic [AgeW-1:0] age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else if (age_q != AgeW'(msis_pkg::Latency)) begin
      age_q <= age_q + 1'b1;
    end
  end

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised although requests are always taken");

  a_strobe_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_q == AgeW'(msis_pkg::Latency)) |-> (done_o == $past(start_i, msis_pkg::Latency)))
    else $error("result strobe does not match request latency");

  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !in_range_o) |->
      (to_note_o == 7'd0 && target_index_o == 7'd0 && scale_degree_o == 4'd0))
    else $error("out of range result carries nonzero fields");

  a_zero_interval_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(interval_steps_i, msis_pkg::Latency) == 8'sd0) |->
      (in_range_o && scale_degree_o == 4'd0 &&
       to_note_o == $past(from_note_i, msis_pkg::Latency)))
    else $error("zero interval does not return the input note");

  a_degree_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && in_range_o && $past(interval_steps_i, msis_pkg::Latency) != 8'sd0) |->
      (scale_degree_o != 4'd0 && scale_degree_o <= 4'd12))
    else $error("scale degree out of range");

endmodule

bind musical_scale_interval_stepper msis_checker u_msis_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .from_note_i      (from_note_i),
  .interval_steps_i (interval_steps_i),
  .done_o           (done_o),
  .to_note_o        (to_note_o),
  .in_range_o       (in_range_o),
  .target_index_o   (target_index_o),
  .scale_degree_o   (scale_degree_o)
);

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench;

  localparam int CycleLimit  = 200000;
  localparam int PhaseCount  = 10;
  localparam int PhaseItems  = 100;
  localparam int DirectedLen = 24;

  // one bit per semitone above the root, bit 0 is the root itself
  localparam logic [11:0] ScaleMasks [19] = '{
    12'hFFF, 12'hAB5, 12'h6AD, 12'h5AB, 12'hAD5, 12'h6B5, 12'h5AD, 12'h56B, 12'h9AD,
    12'hAAD, 12'h295, 12'h4A9, 12'h4E9, 12'hEB5, 12'hB6D, 12'hD53, 12'hAAB, 12'h9AB,
    12'h9CD
  };

  typedef struct packed {
    logic [6:0] to_note;
    logic       in_range;
    logic [6:0] index;
    logic [3:0] degree;
  } step_result_t;

  typedef struct packed {
    logic [4:0]        pattern;
    logic [6:0]        root;
    logic [6:0]        from_note;
    logic signed [7:0] steps;
    logic              typed;
    step_result_t      result;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [6:0]        from_note_i;
  logic signed [7:0] interval_steps_i;
  logic              cfg_we_i;
  logic [0:0]        cfg_idx_i;
  logic [6:0]        cfg_wdata_i;
  logic              done_o;
  logic [6:0]        to_note_o;
  logic              in_range_o;
  logic [6:0]        target_index_o;
  logic [3:0]        scale_degree_o;

  musical_scale_interval_stepper uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .from_note_i      (from_note_i),
    .interval_steps_i (interval_steps_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .to_note_o        (to_note_o),
    .in_range_o       (in_range_o),
    .target_index_o   (target_index_o),
    .scale_degree_o   (scale_degree_o)
  );

  // scale settings as the block sees them, tracked on the write port
  logic [4:0]   scale_pattern_q;
  logic [6:0]   root_note_q;
  step_result_t pending_steps [$];
  int           requests_taken;
  int           mismatch_count;
  int           in_range_count;
  int           out_range_count;
  int           settings_used;
  int           cycle_count;
  int           idle_pct;
  logic         use_typed;
  step_result_t typed_result;
  directed_row_t directed_rows [DirectedLen];

  function automatic step_result_t step_in_scale(logic [4:0] pattern, logic [6:0] root,
                                                 logic [6:0] from_note,
                                                 logic signed [7:0] steps);
    logic [11:0]  mask;
    logic [3:0]   degree_at [12];
    logic [6:0]   scale_note [128];
    logic [3:0]   scale_deg [128];
    int           base;
    int           running;
    int           offset;
    int           count;
    int           below;
    int           target;
    step_result_t r;
    mask = (pattern < 5'd19) ? ScaleMasks[pattern] : 12'h001;
    running = 0;
    for (int o = 0; o < 12; o++) begin
      if (mask[o]) running++;
      degree_at[o] = 4'(running);
    end
    base  = int'(root) % 12;
    count = 0;
    below = 0;
    for (int n = base; n < msis_pkg::NoteCount; n++) begin
      offset = (n - base) % 12;
      if (mask[offset]) begin
        scale_note[count] = 7'(n);
        scale_deg[count]  = degree_at[offset];
        if (n < int'(from_note)) below++;
        count++;
      end
    end
    r = '0;
    if (steps == 8'sd0) begin
      r.to_note  = from_note;
      r.in_range = 1'b1;
      r.index    = 7'(below);
    end else begin
      target = below + int'(steps);
      if (target >= 0 && target < count) begin
        r.to_note  = scale_note[target];
        r.in_range = 1'b1;
        r.index    = 7'(target);
        r.degree   = scale_deg[target];
      end
    end
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_steps.size());
    $display("testbench failed");
    $finish;
  end

  // acceptance, result check and register mirror, all on pre-edge values
  always @(posedge clk_i) begin
    step_result_t seen;
    step_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        seen = '{to_note_o, in_range_o, target_index_o, scale_degree_o};
        if (pending_steps.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: note %0d in_range %0d index %0d degree %0d",
                     seen.to_note, seen.in_range, seen.index, seen.degree);
          end
        end else begin
          want = pending_steps.pop_front();
          if (seen.to_note !== want.to_note || seen.in_range !== want.in_range ||
              seen.index !== want.index || seen.degree !== want.degree) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected note %0d in_range %0d index %0d degree %0d,",
                       want.to_note, want.in_range, want.index, want.degree);
              $display("          got      note %0d in_range %0d index %0d degree %0d",
                       seen.to_note, seen.in_range, seen.index, seen.degree);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        want = use_typed ? typed_result
                         : step_in_scale(scale_pattern_q, root_note_q, from_note_i,
                                         interval_steps_i);
        if (want.in_range) in_range_count++;
        else out_range_count++;
        pending_steps = {pending_steps, want};
        requests_taken++;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == msis_pkg::RegPattern) scale_pattern_q <= cfg_wdata_i[4:0];
        else root_note_q <= cfg_wdata_i;
      end
    end
  end

  task automatic send_note(logic [6:0] from_note, logic signed [7:0] steps);
    int taken;
    while (int'($urandom_range(99)) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    taken            = requests_taken;
    start_i          <= 1'b1;
    from_note_i      <= from_note;
    interval_steps_i <= steps;
    do @(negedge clk_i); while (requests_taken == taken);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (pending_steps.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // the pattern write may carry junk in the bits above the 5-bit register
  task automatic load_scale(logic [6:0] pattern_wdata, logic [6:0] root);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= msis_pkg::RegPattern;
    cfg_wdata_i <= pattern_wdata;
    @(negedge clk_i);
    cfg_idx_i   <= msis_pkg::RegRoot;
    cfg_wdata_i <= root;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  initial begin
    directed_row_t     row;
    logic [6:0]        pat_wdata;
    logic [6:0]        root;
    logic signed [7:0] steps;

    // reset scale is major on middle c
    directed_rows = '{
      '{5'd1,  7'd60,  7'd60,  8'sd0,    1'b1, '{7'd60,  1'b1, 7'd35,  4'd0}},
      '{5'd1,  7'd60,  7'd60,  8'sd1,    1'b1, '{7'd62,  1'b1, 7'd36,  4'd2}},
      '{5'd1,  7'd60,  7'd0,   8'sd1,    1'b1, '{7'd2,   1'b1, 7'd1,   4'd2}},
      '{5'd1,  7'd60,  7'd0,   -8'sd1,   1'b1, '{7'd0,   1'b0, 7'd0,   4'd0}},
      '{5'd1,  7'd60,  7'd0,   -8'sd128, 1'b1, '{7'd0,   1'b0, 7'd0,   4'd0}},
      '{5'd1,  7'd60,  7'd0,   8'sd127,  1'b1, '{7'd0,   1'b0, 7'd0,   4'd0}},
      '{5'd1,  7'd60,  7'd127, 8'sd127,  1'b1, '{7'd0,   1'b0, 7'd0,   4'd0}},
      '{5'd1,  7'd60,  7'd127, -8'sd128, 1'b1, '{7'd0,   1'b0, 7'd0,   4'd0}},
      '{5'd1,  7'd60,  7'd127, 8'sd0,    1'b1, '{7'd127, 1'b1, 7'd74,  4'd0}},
      '{5'd1,  7'd60,  7'd127, -8'sd1,   1'b1, '{7'd125, 1'b1, 7'd73,  4'd4}},
      '{5'd1,  7'd60,  7'd61,  8'sd1,    1'b0, '0},
      '{5'd1,  7'd60,  7'd50,  -8'sd7,   1'b0, '0},
      '{5'd1,  7'd60,  7'd85,  -8'sd74,  1'b0, '0},
      '{5'd1,  7'd60,  7'd1,   8'sd74,   1'b0, '0},
      '{5'd1,  7'd60,  7'd0,   8'sd74,   1'b0, '0},
      // chromatic from note zero: every note is in the scale
      '{5'd0,  7'd0,   7'd0,   8'sd127,  1'b1, '{7'd127, 1'b1, 7'd127, 4'd8}},
      '{5'd0,  7'd0,   7'd127, -8'sd127, 1'b1, '{7'd0,   1'b1, 7'd0,   4'd1}},
      '{5'd0,  7'd0,   7'd127, -8'sd128, 1'b1, '{7'd0,   1'b0, 7'd0,   4'd0}},
      '{5'd18, 7'd127, 7'd64,  -8'sd5,   1'b0, '0},
      '{5'd18, 7'd127, 7'd0,   8'sd1,    1'b0, '0},
      '{5'd18, 7'd127, 7'd3,   -8'sd1,   1'b0, '0},
      // unknown pattern: root notes only
      '{5'd31, 7'd127, 7'd127, -8'sd1,   1'b1, '{7'd115, 1'b1, 7'd9,   4'd1}},
      '{5'd31, 7'd127, 7'd6,   8'sd0,    1'b1, '{7'd6,   1'b1, 7'd0,   4'd0}},
      '{5'd19, 7'd5,   7'd100, 8'sd3,    1'b0, '0}
    };

    rst_ni           = 1'b0;
    start_i          = 1'b0;
    from_note_i      = '0;
    interval_steps_i = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = msis_pkg::RegPattern;
    cfg_wdata_i      = '0;
    scale_pattern_q  = 5'd1;
    root_note_q      = 7'd60;
    requests_taken   = 0;
    mismatch_count   = 0;
    in_range_count   = 0;
    out_range_count  = 0;
    settings_used    = 1;
    idle_pct         = 8;
    use_typed        = 1'b0;
    typed_result     = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.pattern != scale_pattern_q || row.root != root_note_q) begin
        drain();
        load_scale({2'b00, row.pattern}, row.root);
      end
      use_typed    = row.typed;
      typed_result = row.result;
      send_note(row.from_note, row.steps);
    end
    use_typed = 1'b0;

    // sender idles rarely early, often in the middle, never at the end
    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain();
      case (phase)
        0: begin
          pat_wdata = 7'd0;
          root      = 7'd0;
        end
        1: begin
          pat_wdata = 7'd18;
          root      = 7'd127;
        end
        2: begin
          pat_wdata = {2'b11, 5'd31};
          root      = 7'd11;
        end
        default: begin
          if ($urandom_range(4) == 0) pat_wdata = 7'($urandom_range(19, 127));
          else pat_wdata = {2'($urandom_range(3)), 5'($urandom_range(18))};
          root = 7'($urandom_range(127));
        end
      endcase
      load_scale(pat_wdata, root);
      idle_pct = (phase < 4) ? 8 : (phase < 7) ? 63 : 0;
      for (int k = 0; k < PhaseItems; k++) begin
        // mostly short moves so targets land inside the scale
        if ($urandom_range(9) < 6) steps = 8'(int'($urandom_range(40)) - 20);
        else steps = 8'($urandom_range(255));
        send_note(7'($urandom_range(127)), steps);
      end
    end

    start_i <= 1'b0;
    while (pending_steps.size() != 0) @(negedge clk_i);
    repeat (2 * msis_pkg::Latency) @(negedge clk_i);

    $display("%0d note requests over %0d scale settings", requests_taken, settings_used);
    $display("%0d steps inside the scale, %0d outside, %0d mismatches", in_range_count,
             out_range_count, mismatch_count);
    if (mismatch_count == 0 && pending_steps.size() == 0) begin
      $display("testbench passed");
    end else begin
      if (pending_steps.size() != 0) begin
        $display("%0d results never arrived", pending_steps.size());
      end
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
src/msis_pkg.sv
src/musical_scale_interval_stepper.sv
src/msis_checker.sv
verif/testbench.sv
